### design/srtf_scheduler_with_io_defines.svh
// Assertion macros for the scheduler checker
`ifndef SRTF_SCHEDULER_WITH_IO_DEFINES_SVH
`define SRTF_SCHEDULER_WITH_IO_DEFINES_SVH
// assert that an antecedent implies a consequent on the next cycle
`define SRTF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%s failed", "label");
// assert that an antecedent implies a consequent in the same cycle
`define SRTF_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%s failed", "label");
`endif

### design/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package srtf_pkg;
  localparam int MaxProcs  = 16;
  localparam int MaxIoOps  = 4;
  localparam int TimeBits  = 16;
  localparam int IdxBits   = $clog2(MaxProcs);
  localparam int SlotBits  = $clog2(MaxIoOps);
  localparam int CntBits   = $clog2(MaxProcs + 1);
  localparam int IoCntBits = $clog2(MaxIoOps + 1);
  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  localparam logic [1:0] CmdLoadProc = 2'd0;
  localparam logic [1:0] CmdLoadIo   = 2'd1;
  localparam logic [1:0] CmdTick     = 2'd2;
  localparam logic [1:0] CmdRestart  = 2'd3;

  typedef struct packed {
    logic [1:0]          command;
    logic [IdxBits-1:0]  proc_index;
    logic [TimeBits-1:0] arrive_tick;
    logic [TimeBits-1:0] burst_time;
    logic [2:0]          io_total;
    logic [SlotBits-1:0] io_slot;
    logic [TimeBits-1:0] io_start;
    logic [TimeBits-1:0] io_duration;
  } item_t;

  typedef struct packed {
    logic                idle;
    logic [IdxBits-1:0]  running_index;
    logic                first_run;
    logic [TimeBits-1:0] response_ticks;
    logic                finished_now;
    logic [TimeBits-1:0] completion_tick;
    logic                io_begun;
    logic                all_done;
    logic [TimeBits-1:0] current_tick;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic               load;     // capture item
    logic               exec;     // do load or restart on held item
    logic               dec;      // countdown pass (scheduled entries)
    logic               scan;     // compare entry at idx
    logic               scan_first;
    logic [IdxBits-1:0] idx;
    logic               commit;   // update chosen entry, build result
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
  } stat_t;
endpackage
`default_nettype wire

### design/srtf_ctrl.sv
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer: load/restart in one step, tick as countdown, scan, commit.
// ----------------------------------------------------------------------------
`default_nettype none
module srtf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_fire_i,
  output logic                 in_ready_o,
  input  wire logic            out_busy_i,
  input  wire logic [4:0]      count_i,
  input  wire srtf_pkg::stat_t stat_i,
  output srtf_pkg::cmd_t       cmd_o,
  output logic                 out_push_o
);
  typedef enum logic [4:0] {
    StIdle = 5'b00001, StExec = 5'b00010, StDec = 5'b00100,
    StScan = 5'b01000, StCommit = 5'b10000
  } state_e;
  state_e state_q, state_d;
  logic [srtf_pkg::CntBits-1:0] idx_q, idx_d, lim;

  always_comb begin
    if (count_i > 5'(srtf_pkg::MaxProcs)) lim = srtf_pkg::CntBits'(srtf_pkg::MaxProcs);
    else lim = srtf_pkg::CntBits'(count_i);
  end

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.idx = idx_q[srtf_pkg::IdxBits-1:0];
    out_push_o = 1'b0;
    case (state_q)
      StIdle: begin
        cmd_o.load = in_fire_i;
        if (in_fire_i) state_d = StExec;
      end
      StExec: begin
        if (stat_i.command == srtf_pkg::CmdTick) begin
          state_d = StDec;
        end else begin
          cmd_o.exec = 1'b1;
          state_d = StIdle;
        end
      end
      StDec: begin
        cmd_o.dec = 1'b1;
        idx_d = '0;
        state_d = StScan;
      end
      StScan: begin
        if (idx_q < lim) begin
          cmd_o.scan = 1'b1;
          cmd_o.scan_first = (idx_q == '0);
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        if (!out_busy_i) begin
          cmd_o.commit = 1'b1;
          out_push_o = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end
endmodule
`default_nettype wire

### design/srtf_dp.sv
// ----------------------------------------------------------------------------
// srtf_dp
// Process tables, run state, selection registers and result build.
// ----------------------------------------------------------------------------
`default_nettype none
module srtf_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire srtf_pkg::item_t  item_i,
  input  wire logic [4:0]       count_i,
  input  wire srtf_pkg::cmd_t   cmd_i,
  output srtf_pkg::stat_t       stat_o,
  output srtf_pkg::result_t     res_o
);
  localparam int N = srtf_pkg::MaxProcs;
  localparam int TB = srtf_pkg::TimeBits;
  localparam int IB = srtf_pkg::IdxBits;
  localparam int SB = srtf_pkg::SlotBits;
  localparam int NS = N * srtf_pkg::MaxIoOps;

  srtf_pkg::item_t it_q;
  logic [TB-1:0] arr_q [N];
  logic [TB-1:0] bur_q [N];
  logic [2:0]    ioc_q [N];
  logic [TB-1:0] ios_mem [NS];
  logic [TB-1:0] iol_mem [NS];
  logic [TB-1:0] rem_q [N];
  logic [TB-1:0] ran_q [N];
  logic [srtf_pkg::IoCntBits-1:0] nio_q [N];
  logic [TB-1:0] blk_q [N];
  logic [N-1:0]  fresh_q, done_q, start_q;
  logic [TB-1:0] clk_q;

  logic          have_q;
  logic [IB-1:0] pick_q;
  logic [TB-1:0] prem_q, parr_q;
  logic [TB-1:0] ios_rd_q, iol_rd_q;

  assign stat_o.command = it_q.command;

  // candidate test at scan index
  logic [IB-1:0] si;
  logic          elig, better;
  assign si = cmd_i.idx;
  always_comb begin
    elig = !done_q[si] && (blk_q[si] == '0) && (arr_q[si] <= clk_q) && (rem_q[si] != '0);
    better = !have_q || cmd_i.scan_first || (rem_q[si] < prem_q) ||
             ((rem_q[si] == prem_q) && (arr_q[si] < parr_q));
  end

  // commit computations on the chosen entry
  logic [TB-1:0] rem_n, ran_n;
  logic [srtf_pkg::IoCntBits-1:0] iolim;
  logic fin, iob;
  logic [N-1:0] valid_m, done_n;
  logic [srtf_pkg::CntBits-1:0] lim;
  srtf_pkg::result_t res_n;
  always_comb begin
    rem_n = prem_q - 1'b1;
    ran_n = (ran_q[pick_q] == srtf_pkg::TimeMax) ? ran_q[pick_q] : ran_q[pick_q] + 1'b1;
    iolim = (ioc_q[pick_q] > 3'(srtf_pkg::MaxIoOps)) ?
            srtf_pkg::IoCntBits'(srtf_pkg::MaxIoOps) : srtf_pkg::IoCntBits'(ioc_q[pick_q]);
    fin = have_q && (rem_n == '0);
    iob = have_q && !fin && (nio_q[pick_q] < iolim) && (ran_n == ios_rd_q);
    lim = (count_i > 5'(N)) ? srtf_pkg::CntBits'(N) : srtf_pkg::CntBits'(count_i);
    done_n = done_q;
    if (fin) done_n[pick_q] = 1'b1;
    for (int k = 0; k < N; k++) valid_m[k] = (k < int'(lim));
  end

  // tick result as it will be committed
  always_comb begin
    res_n = '0;
    res_n.idle = !have_q;
    res_n.current_tick = clk_q;
    res_n.all_done = ((done_n & valid_m) == valid_m);
    if (have_q) begin
      res_n.running_index = pick_q;
      res_n.first_run = !start_q[pick_q];
      if (!start_q[pick_q]) res_n.response_ticks = clk_q - parr_q;
      res_n.finished_now = fin;
      if (fin)
        res_n.completion_tick = (clk_q == srtf_pkg::TimeMax) ? clk_q : clk_q + 1'b1;
      res_n.io_begun = iob;
    end
  end

  // io slot read address follows the chosen entry
  logic [$clog2(NS)-1:0] rd_addr, wr_addr;
  assign rd_addr = {pick_q, nio_q[pick_q][SB-1:0]};
  assign wr_addr = {it_q.proc_index, it_q.io_slot};

  always_ff @(posedge clk_i) begin
    ios_rd_q <= ios_mem[rd_addr];
    iol_rd_q <= iol_mem[rd_addr];
    if (cmd_i.exec && it_q.command == srtf_pkg::CmdLoadIo) begin
      ios_mem[wr_addr] <= it_q.io_start;
      iol_mem[wr_addr] <= it_q.io_duration;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
    if (cmd_i.exec && it_q.command == srtf_pkg::CmdLoadProc) begin
      arr_q[it_q.proc_index] <= it_q.arrive_tick;
      bur_q[it_q.proc_index] <= it_q.burst_time;
      ioc_q[it_q.proc_index] <= it_q.io_total;
    end
    if (cmd_i.scan && elig && better) begin
      pick_q <= si;
      prem_q <= rem_q[si];
      parr_q <= arr_q[si];
    end
    if (cmd_i.commit) res_o <= res_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= '0; ran_q[k] <= '0; nio_q[k] <= '0; blk_q[k] <= '0;
      end
      fresh_q <= '0; done_q <= '0; start_q <= '0; clk_q <= '0; have_q <= 1'b0;
    end else begin
      if (cmd_i.exec && it_q.command == srtf_pkg::CmdLoadProc) begin
        rem_q[it_q.proc_index] <= it_q.burst_time;
        ran_q[it_q.proc_index] <= '0;
        nio_q[it_q.proc_index] <= '0;
        blk_q[it_q.proc_index] <= '0;
        fresh_q[it_q.proc_index] <= 1'b0;
        done_q[it_q.proc_index]  <= 1'b0;
        start_q[it_q.proc_index] <= 1'b0;
      end
      if (cmd_i.exec && it_q.command == srtf_pkg::CmdRestart) begin
        for (int k = 0; k < N; k++) begin
          rem_q[k] <= bur_q[k]; ran_q[k] <= '0; nio_q[k] <= '0; blk_q[k] <= '0;
        end
        fresh_q <= '0; done_q <= '0; start_q <= '0; clk_q <= '0;
      end
      if (cmd_i.dec) begin
        for (int k = 0; k < N; k++) begin
          if (valid_m[k]) begin
            if (blk_q[k] != '0 && !fresh_q[k]) blk_q[k] <= blk_q[k] - 1'b1;
            fresh_q[k] <= 1'b0;
          end
        end
        have_q <= 1'b0;
      end
      if (cmd_i.scan && elig) have_q <= 1'b1;
      else if (cmd_i.scan && cmd_i.scan_first) have_q <= 1'b0;
      if (cmd_i.commit) begin
        if (have_q) begin
          start_q[pick_q] <= 1'b1;
          rem_q[pick_q] <= rem_n;
          ran_q[pick_q] <= ran_n;
          done_q <= done_n;
          if (iob) begin
            blk_q[pick_q] <= iol_rd_q;
            nio_q[pick_q] <= nio_q[pick_q] + 1'b1;
            fresh_q[pick_q] <= 1'b1;
          end
        end
        clk_q <= (clk_q == srtf_pkg::TimeMax) ? clk_q : clk_q + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### design/srtf_scheduler_with_io.sv
// ----------------------------------------------------------------------------
// srtf_scheduler_with_io
// Preemptive shortest-remaining-time scheduler with I/O blocking.
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// s_axis    in         tvalid/tready    command, index, times, io fields
// m_axis    out        tvalid/tready    tick result
// apb       in         psel/penable     scheduled entry count at address 0
// Load and restart commands pass through the accept state and the execute
// state. A tick passes through the accept state, a decode state, a countdown
// pass, a sequential scan of min(count,16) entries at one entry per cycle
// plus a closing step, and a commit state.
// Reset is asynchronous; no clearing pass is needed.
// One output register holds the result; commit waits while it is full and
// not being taken.
`default_nettype none
module srtf_scheduler_with_io (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[1:0] proc_index[5:2] arrive_tick[21:6] burst_time[37:22]
  // io_total[40:38] io_slot[42:41] io_start[58:43] io_duration[74:59]
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // idle[0] running_index[4:1] first_run[5] response_ticks[21:6]
  // finished_now[22] completion_tick[38:23] io_begun[39] all_done[40]
  // current_tick[56:41]
  output logic [63:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  srtf_pkg::item_t   item;
  srtf_pkg::result_t res;
  srtf_pkg::cmd_t    cmd;
  srtf_pkg::stat_t   stat;
  logic [4:0] count_q;
  logic push, fire;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {27'd0, count_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= 5'd1;
    else if (psel && penable && pwrite && paddr == 2'd0) count_q <= pwdata[4:0];
  end

  assign item.command      = s_axis_tdata[1:0];
  assign item.proc_index   = s_axis_tdata[5:2];
  assign item.arrive_tick  = s_axis_tdata[21:6];
  assign item.burst_time   = s_axis_tdata[37:22];
  assign item.io_total     = s_axis_tdata[40:38];
  assign item.io_slot      = s_axis_tdata[42:41];
  assign item.io_start     = s_axis_tdata[58:43];
  assign item.io_duration  = s_axis_tdata[74:59];
  assign fire = s_axis_tvalid && s_axis_tready;

  srtf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(fire), .in_ready_o(s_axis_tready),
    .out_busy_i(m_axis_tvalid && !m_axis_tready), .count_i(count_q),
    .stat_i(stat), .cmd_o(cmd), .out_push_o(push)
  );
  srtf_dp u_dp (
    .clk_i, .rst_ni, .item_i(item), .count_i(count_q), .cmd_i(cmd),
    .stat_o(stat), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (push) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  assign m_axis_tdata = {7'd0, res.current_tick, res.all_done, res.io_begun,
                         res.completion_tick, res.finished_now, res.response_ticks,
                         res.first_run, res.running_index, res.idle};
endmodule
`default_nettype wire

### design/srtf_checker.sv
// ----------------------------------------------------------------------------
// srtf_port_checker
// Port-level checks of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
`include "srtf_scheduler_with_io_defines.svh"
module srtf_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        pready
);
  `SRTF_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `SRTF_ASSERT_NEXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SRTF_ASSERT_NOW(a_idle_idx, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[4:1] == 4'd0 && !m_axis_tdata[5] && !m_axis_tdata[22])
  `SRTF_ASSERT_NOW(a_pready, clk_i, rst_ni, 1'b1, pready)
endmodule
bind srtf_scheduler_with_io srtf_port_checker u_chk (.*);
`default_nettype wire
